/* src/i2crev_pkg.sv */
package i2crev_pkg;

	localparam int RX_DEPTH = 256;
	localparam int TX_DEPTH = 64;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam logic [8:0] TX_LIMIT = 9'(TX_DEPTH);

	localparam int BYTE_W = 8;
	localparam int EVENT_W = 4;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [3:0] {
		EV_ADDR_WR = 4'd0,
		EV_RX_ACK = 4'd1,
		EV_RX_NACK = 4'd2,
		EV_STOP = 4'd3,
		EV_ADDR_RD = 4'd4,
		EV_TX_ACK = 4'd5,
		EV_TX_NACK = 4'd6,
		EV_BUS_ERR = 4'd7,
		EV_OTHER = 4'd8
	} event_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ADDR = 3'd1,
		PH_CHECK = 3'd2,
		PH_RX = 3'd3,
		PH_TX = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ACT_RELEASE = 2'd0,
		ACT_RECOVER = 2'd1,
		ACT_NONE = 2'd2
	} action_t;

endpackage

/* src/i2crev_ram.sv */
module i2crev_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/i2c_slave_reverse_echo.sv */
// Channel  | Dir | Handshake         | Contents
// s_*      | in  | s_tvalid/s_tready | tuser: event_req; tdata: rx_byte
// m_*      | out | m_tvalid/m_tready | tuser: tx_loaded; tdata: tx_byte, bus_action,
//          |     |                   |        saved_length
//
// One event per cycle while the output is not stalled; each result passes the stage-1 and output registers.
// Control state updates at accept; the receive buffer RAM is read in the same
// cycle and its registered read data forms the result one stage later.
// Reset clears phase, counters and valid flags only; buffer contents stay undefined.
// A stalled output holds one result and the stage behind it; input stalls then.
module i2c_slave_reverse_echo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [i2crev_pkg::IN_DATA_W-1:0]   s_tdata,  // [7:0] rx_byte
	input  logic [i2crev_pkg::EVENT_W-1:0]     s_tuser,  // [3:0] event_req
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [i2crev_pkg::OUT_DATA_W-1:0]  m_tdata,  // [7:0] tx_byte, [9:8] bus_action,
	                                                     // [17:10] saved_length, [23:18] zero
	output logic                               m_tuser   // [0] tx_loaded
);
	import i2crev_pkg::*;

	event_t ev;
	logic [BYTE_W-1:0] rx_byte;
	logic acc;

	phase_t phase_q, phase_d;
	logic [BYTE_W-1:0] rx_count_q, rx_count_d;
	logic [BYTE_W-1:0] echo_count_q, echo_count_d;
	logic [BYTE_W-1:0] tx_index_q, tx_index_d;

	logic wr_c, hit_c, loaded_c;
	action_t action_c;
	logic [BYTE_W-1:0] pos_c;
	logic [BYTE_W-1:0] rdata;

	logic valid_s1, hit_s1, loaded_s1;
	action_t action_s1;
	logic [BYTE_W-1:0] saved_s1;
	logic adv_s1;

	logic out_valid_q, out_loaded_q;
	logic [BYTE_W-1:0] out_byte_q, out_saved_q;
	action_t out_action_q;

	assign ev = event_t'(s_tuser);
	assign rx_byte = s_tdata[BYTE_W-1:0];
	assign acc = s_tvalid && s_tready;

	always_comb begin
		phase_d = phase_q;
		rx_count_d = rx_count_q;
		echo_count_d = echo_count_q;
		tx_index_d = tx_index_q;
		wr_c = 1'b0;
		hit_c = 1'b0;
		pos_c = echo_count_q - 8'd1 - tx_index_q;
		loaded_c = (ev == EV_ADDR_RD) || (ev == EV_TX_ACK);
		if (s_tuser <= EVENT_W'(EV_TX_NACK)) begin
			action_c = ACT_RELEASE;
		end else if (ev == EV_BUS_ERR) begin
			action_c = ACT_RECOVER;
		end else begin
			action_c = ACT_NONE;
		end
		if (ev == EV_ADDR_WR) begin
			phase_d = PH_ADDR;
			rx_count_d = '0;
			tx_index_d = '0;
		end
		case (phase_d)
			PH_ADDR: begin
				if (ev == EV_RX_ACK) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (ev == EV_RX_ACK) begin
					wr_c = 1'b1;
					rx_count_d = rx_count_q + 8'd1;
					phase_d = PH_RX;
				end else if (ev == EV_STOP) begin
					phase_d = PH_TX;
				end
			end
			PH_RX: begin
				if (ev == EV_STOP) begin
					echo_count_d = rx_count_q;
					phase_d = PH_IDLE;
				end else if (ev == EV_RX_ACK) begin
					wr_c = 1'b1;
					rx_count_d = rx_count_q + 8'd1;
				end
			end
			PH_TX: begin
				if (loaded_c) begin
					hit_c = (tx_index_q < echo_count_q) && ({1'b0, tx_index_q} < TX_LIMIT);
					tx_index_d = tx_index_q + 8'd1;
				end else if (ev == EV_TX_NACK) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rx_count_q <= '0;
			echo_count_q <= '0;
			tx_index_q <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			rx_count_q <= rx_count_d;
			echo_count_q <= echo_count_d;
			tx_index_q <= tx_index_d;
		end
	end

	i2crev_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(RX_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (acc && wr_c),
		.waddr(RX_AW'(rx_count_q)),
		.wdata(rx_byte),
		.re   (acc && hit_c),
		.raddr(RX_AW'(pos_c)),
		.rdata(rdata)
	);

	assign adv_s1 = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hit_s1 <= hit_c;
			loaded_s1 <= loaded_c;
			action_s1 <= action_c;
			saved_s1 <= echo_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_byte_q <= hit_s1 ? rdata : '0;
			out_loaded_q <= loaded_s1;
			out_action_q <= action_s1;
			out_saved_q <= saved_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_loaded_q;
	assign m_tdata = {6'd0, out_saved_q, out_action_q, out_byte_q};

endmodule

/* bench/i2c_slave_reverse_echo_test.sv */
module i2c_slave_reverse_echo_test;
	timeunit 1ns;
	timeprecision 1ps;

	import i2crev_pkg::*;

	typedef struct packed {
		logic                 hold;
		logic [EVENT_W-1:0]   ev;
		logic [BYTE_W-1:0]    data;
	} bus_event_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    tx_byte;
		logic                 tx_loaded;
		action_t              action;
		logic [BYTE_W-1:0]    saved_len;
	} echo_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_W-1:0]     s_tdata = '0;  // [7:0] rx_byte
	logic [EVENT_W-1:0]       s_tuser = '0;  // [3:0] event_req
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]    m_tdata;       // [7:0] tx_byte, [9:8] bus_action,
	                                         // [17:10] saved_length, [23:18] zero
	logic                     m_tuser;       // [0] tx_loaded

	bus_event_t               pending [$];
	echo_result_t             echo_expected [$];
	echo_result_t             want;

	phase_t                   ph = PH_IDLE;
	logic [BYTE_W-1:0]        rx_store_copy [RX_DEPTH];
	logic [BYTE_W-1:0]        rx_cnt = '0;
	logic [BYTE_W-1:0]        echo_cnt = '0;
	logic [BYTE_W-1:0]        tx_idx = '0;

	int                       cyc = 0;
	int                       n_queued = 0;
	int                       n_sent = 0;
	int                       n_checked = 0;
	int                       n_echoed = 0;
	int                       max_saved = 0;
	int                       n_fail = 0;
	logic                     steady;

	i2c_slave_reverse_echo i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	assign steady = (cyc >= 300) && (cyc < 700);

	function automatic echo_result_t predict_echo(input logic [EVENT_W-1:0] ev,
			input logic [BYTE_W-1:0] data);
		echo_result_t r;
		r.tx_byte = '0;
		r.tx_loaded = (ev == EV_ADDR_RD) || (ev == EV_TX_ACK);
		if (ev <= EV_TX_NACK) begin
			r.action = ACT_RELEASE;
		end else if (ev == EV_BUS_ERR) begin
			r.action = ACT_RECOVER;
		end else begin
			r.action = ACT_NONE;
		end
		if (ev == EV_ADDR_WR) begin
			ph = PH_ADDR;
			rx_cnt = '0;
			tx_idx = '0;
		end
		case (ph)
			PH_ADDR: begin
				if (ev == EV_RX_ACK)
					ph = PH_CHECK;
			end
			PH_CHECK: begin
				if (ev == EV_RX_ACK) begin
					rx_store_copy[rx_cnt % RX_DEPTH] = data;
					rx_cnt = rx_cnt + 8'd1;
					ph = PH_RX;
				end else if (ev == EV_STOP) begin
					ph = PH_TX;
				end
			end
			PH_RX: begin
				if (ev == EV_STOP) begin
					echo_cnt = rx_cnt;
					ph = PH_IDLE;
				end else if (ev == EV_RX_ACK) begin
					rx_store_copy[rx_cnt % RX_DEPTH] = data;
					rx_cnt = rx_cnt + 8'd1;
				end
			end
			PH_TX: begin
				if (r.tx_loaded) begin
					if (tx_idx < echo_cnt && tx_idx < TX_DEPTH) begin
						r.tx_byte = rx_store_copy[(echo_cnt - 8'd1 - tx_idx) % RX_DEPTH];
						n_echoed++;
					end
					tx_idx = tx_idx + 8'd1;
				end else if (ev == EV_TX_NACK) begin
					ph = PH_IDLE;
				end
			end
			default: ;
		endcase
		if (echo_cnt > max_saved)
			max_saved = echo_cnt;
		r.saved_len = echo_cnt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				echo_expected.push_back(predict_echo(s_tuser, s_tdata));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending.size() != 0 && (steady || $urandom_range(99) >= 13)
						&& !(pending[0].hold && echo_expected.size() != 0)) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending[0].ev;
					s_tdata <= pending[0].data;
					void'(pending.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (echo_expected.size() == 0) begin
					$error("result with no pending event: tdata %0h tuser %0b", m_tdata, m_tuser);
					n_fail++;
				end else begin
					want = echo_expected.pop_front();
					n_checked++;
					if (m_tdata[7:0] !== want.tx_byte) begin
						$error("tx_byte: expected %0h, got %0h", want.tx_byte, m_tdata[7:0]);
						n_fail++;
					end
					if (m_tuser !== want.tx_loaded) begin
						$error("tx_loaded: expected %0b, got %0b", want.tx_loaded, m_tuser);
						n_fail++;
					end
					if (m_tdata[9:8] !== want.action) begin
						$error("bus_action: expected %0d, got %0d", want.action, m_tdata[9:8]);
						n_fail++;
					end
					if (m_tdata[17:10] !== want.saved_len) begin
						$error("saved_length: expected %0d, got %0d", want.saved_len,
							m_tdata[17:10]);
						n_fail++;
					end
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 13);
		end
	end

	task automatic send(input logic [EVENT_W-1:0] ev, input logic [BYTE_W-1:0] data,
			input logic hold);
		bus_event_t e;
		e.hold = hold;
		e.ev = ev;
		e.data = data;
		pending.push_back(e);
		n_queued++;
	endtask

	// address write, register byte, payload, stop
	task automatic write_frame(input int len);
		send(EV_ADDR_WR, 8'($urandom), 1'b0);
		send(EV_RX_ACK, 8'($urandom), 1'b0);
		repeat (len) send(EV_RX_ACK, 8'($urandom), 1'b0);
		send(EV_STOP, 8'($urandom), 1'b0);
	endtask

	// arm with a write that carries only a register byte, then read len bytes back
	task automatic read_frame(input int len, input logic hold);
		send(EV_ADDR_WR, 8'($urandom), hold);
		send(EV_RX_ACK, 8'($urandom), 1'b0);
		send(EV_STOP, 8'($urandom), 1'b0);
		send(EV_ADDR_RD, 8'($urandom), 1'b0);
		repeat (len - 1) send(EV_TX_ACK, 8'($urandom), 1'b0);
		send(EV_TX_NACK, 8'($urandom), 1'b0);
	endtask

	initial begin
		int pick;

		send(EV_OTHER, 8'hFF, 1'b0);
		send(4'd15, 8'h00, 1'b0);
		send(EV_BUS_ERR, 8'h5A, 1'b0);
		send(EV_RX_NACK, 8'hFF, 1'b0);
		send(EV_TX_NACK, 8'h00, 1'b0);
		send(EV_ADDR_RD, 8'hFF, 1'b0);
		send(EV_TX_ACK, 8'h00, 1'b0);
		send(EV_STOP, 8'hFF, 1'b0);
		send(EV_RX_ACK, 8'h33, 1'b0);

		send(EV_ADDR_WR, 8'h00, 1'b0);
		send(EV_RX_ACK, 8'h10, 1'b0);
		send(EV_RX_ACK, 8'h00, 1'b0);
		send(EV_RX_ACK, 8'hFF, 1'b0);
		send(EV_RX_ACK, 8'hA5, 1'b0);
		send(EV_RX_NACK, 8'h77, 1'b0);
		send(EV_STOP, 8'h00, 1'b0);

		send(EV_ADDR_WR, 8'h00, 1'b1);
		send(EV_RX_ACK, 8'h10, 1'b0);
		send(EV_STOP, 8'h00, 1'b0);
		send(EV_ADDR_RD, 8'h00, 1'b0);
		send(EV_TX_ACK, 8'h00, 1'b0);
		send(EV_TX_ACK, 8'hFF, 1'b0);
		send(EV_TX_ACK, 8'h00, 1'b0);
		send(EV_TX_NACK, 8'h00, 1'b0);

		write_frame($urandom_range(66, 120));
		read_frame($urandom_range(70, 90), 1'b1);
		write_frame($urandom_range(256, 300));
		read_frame($urandom_range(20, 40), 1'b0);

		while (n_queued < 900) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				write_frame(($urandom_range(99) < 90) ? $urandom_range(0, 12)
					: $urandom_range(60, 80));
			end else if (pick < 75) begin
				read_frame(($urandom_range(99) < 90) ? $urandom_range(1, 12)
					: $urandom_range(60, 80), $urandom_range(19) == 0);
			end else if (pick < 90) begin
				send(EV_ADDR_WR, 8'($urandom), 1'b0);
				send(EV_RX_ACK, 8'($urandom), 1'b0);
				repeat ($urandom_range(0, 5)) send(EV_RX_ACK, 8'($urandom), 1'b0);
				send(4'($urandom_range(15)), 8'($urandom), 1'b0);
				repeat ($urandom_range(0, 3)) send(EV_RX_ACK, 8'($urandom), 1'b0);
				send(EV_STOP, 8'($urandom), 1'b0);
			end else begin
				repeat ($urandom_range(1, 4)) send(4'($urandom_range(15)), 8'($urandom), 1'b0);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || s_tvalid || echo_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Drove %0d bus events and checked %0d results; %0d bytes echoed back",
			n_sent, n_checked, n_echoed);
		$display("from the receive store, largest saved length %0d.", max_saved);
		if (n_fail == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#1ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* filelist.f */
src/i2crev_pkg.sv
src/i2crev_ram.sv
src/i2c_slave_reverse_echo.sv
bench/i2c_slave_reverse_echo_test.sv
